// ----- src/rpwu_pkg.sv -----
`default_nettype none
// rpwu_pkg: shared constants, types and helpers of the rprop weight update engine
package rpwu_pkg;

  localparam int ENTRY_COUNT = 1024;
  localparam int ADDR_W      = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;

  localparam int IDX_W    = 10;
  localparam int VAL_W    = 32;
  localparam int STEP_W   = 31;
  localparam int GROW_W   = 18;
  localparam int SHRINK_W = 16;
  localparam int PROD_W   = STEP_W + GROW_W;
  localparam int FRAC_W   = 16;
  localparam int ENTRY_W  = 3 * VAL_W + STEP_W;

  // operation codes
  localparam logic [1:0] OP_LOAD = 2'd0;
  localparam logic [1:0] OP_ACC  = 2'd1;
  localparam logic [1:0] OP_UPD  = 2'd2;
  localparam logic [1:0] OP_READ = 2'd3;

  // step kind codes
  localparam logic [1:0] KIND_GREW   = 2'd0;
  localparam logic [1:0] KIND_SHRANK = 2'd1;
  localparam logic [1:0] KIND_SAME   = 2'd2;
  localparam logic [1:0] KIND_NONE   = 2'd3;

  // gradient direction codes
  localparam logic [1:0] DIR_GROW   = 2'd0;
  localparam logic [1:0] DIR_SHRINK = 2'd1;
  localparam logic [1:0] DIR_ZERO   = 2'd2;

  // configuration register indexes
  localparam logic [2:0] REG_GROW    = 3'd0;
  localparam logic [2:0] REG_SHRINK  = 3'd1;
  localparam logic [2:0] REG_MAXSTEP = 3'd2;
  localparam logic [2:0] REG_MINSTEP = 3'd3;
  localparam logic [2:0] REG_INITSTEP = 3'd4;

  localparam int PADDR_W = 5;

  typedef struct packed {
    logic signed [VAL_W-1:0] weight;
    logic [STEP_W-1:0]       step;
    logic signed [VAL_W-1:0] prev;
    logic signed [VAL_W-1:0] sum;
  } entry_t;

  typedef struct packed {
    logic [GROW_W-1:0]   grow_factor;
    logic [SHRINK_W-1:0] shrink_factor;
    logic [STEP_W-1:0]   max_step;
    logic [STEP_W-1:0]   min_step;
    logic [STEP_W-1:0]   initial_step;
  } cfg_t;

  // sign of prev times sign of sum
  function automatic logic [1:0] grad_dir(input logic signed [VAL_W-1:0] prev,
                                          input logic signed [VAL_W-1:0] sum);
    logic nz;
    nz = (prev != '0) && (sum != '0);
    if (!nz) begin
      return DIR_ZERO;
    end else if (prev[VAL_W-1] == sum[VAL_W-1]) begin
      return DIR_GROW;
    end else begin
      return DIR_SHRINK;
    end
  endfunction

endpackage
`default_nettype wire

// ----- src/rpwu_ram.sv -----
`default_nettype none
// rpwu_ram: generic single port ram with registered read
module rpwu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                     clk,
  input  wire logic                                     we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
  input  wire logic [WIDTH-1:0]                         wdata,
  output logic      [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    rdata <= mem_r[addr];
  end

endmodule
`default_nettype wire

// ----- src/rpwu_cfg.sv -----
`default_nettype none
// rpwu_cfg: apb register file holding the update factors and step limits
module rpwu_cfg (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [rpwu_pkg::PADDR_W-1:0]   paddr,
  input  wire logic [31:0]                    pwdata,
  output logic      [31:0]                    prdata,
  output rpwu_pkg::cfg_t                      cfg
);

  rpwu_pkg::cfg_t cfg_r;
  logic [2:0]     reg_idx;
  logic           wr_en;

  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite;
  assign cfg     = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.grow_factor   <= rpwu_pkg::GROW_W'(78643);
      cfg_r.shrink_factor <= rpwu_pkg::SHRINK_W'(32768);
      cfg_r.max_step      <= rpwu_pkg::STEP_W'(3276800);
      cfg_r.min_step      <= rpwu_pkg::STEP_W'(1);
      cfg_r.initial_step  <= rpwu_pkg::STEP_W'(6554);
    end else if (wr_en) begin
      case (reg_idx)
        rpwu_pkg::REG_GROW:     cfg_r.grow_factor   <= pwdata[rpwu_pkg::GROW_W-1:0];
        rpwu_pkg::REG_SHRINK:   cfg_r.shrink_factor <= pwdata[rpwu_pkg::SHRINK_W-1:0];
        rpwu_pkg::REG_MAXSTEP:  cfg_r.max_step      <= pwdata[rpwu_pkg::STEP_W-1:0];
        rpwu_pkg::REG_MINSTEP:  cfg_r.min_step      <= pwdata[rpwu_pkg::STEP_W-1:0];
        rpwu_pkg::REG_INITSTEP: cfg_r.initial_step  <= pwdata[rpwu_pkg::STEP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      rpwu_pkg::REG_GROW:     prdata = 32'(cfg_r.grow_factor);
      rpwu_pkg::REG_SHRINK:   prdata = 32'(cfg_r.shrink_factor);
      rpwu_pkg::REG_MAXSTEP:  prdata = 32'(cfg_r.max_step);
      rpwu_pkg::REG_MINSTEP:  prdata = 32'(cfg_r.min_step);
      rpwu_pkg::REG_INITSTEP: prdata = 32'(cfg_r.initial_step);
      default:                prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

// ----- src/rpwu_calc.sv -----
`default_nettype none
// rpwu_calc: modify step of the read-modify-write, computes the new entry
module rpwu_calc (
  input  wire logic [1:0]                          op,
  input  wire logic signed [rpwu_pkg::VAL_W-1:0]   operand,
  input  wire rpwu_pkg::entry_t                    ent,
  input  wire logic [rpwu_pkg::PROD_W-1:0]         prod,
  input  wire rpwu_pkg::cfg_t                      cfg,
  output rpwu_pkg::entry_t                         nxt,
  output logic [1:0]                               kind,
  output logic                                     sat
);

  localparam int VW = rpwu_pkg::VAL_W;
  localparam int SW = rpwu_pkg::STEP_W;
  localparam int RND_W = rpwu_pkg::PROD_W + 1 - rpwu_pkg::FRAC_W;

  logic [1:0]                    dir;
  logic [rpwu_pkg::PROD_W:0]     rnd_full;
  logic [RND_W-1:0]              rnd;
  logic [SW-1:0]                 grown;
  logic [SW-1:0]                 shrunk;
  logic [SW-1:0]                 mv_step;
  logic signed [VW:0]            w_ext;
  logic signed [VW:0]            w_mv;
  logic signed [VW-1:0]          w_clip;
  logic                          w_sat;
  logic signed [VW:0]            acc;
  logic signed [VW-1:0]          acc_clip;
  logic                          acc_sat;

  assign dir = rpwu_pkg::grad_dir(ent.prev, ent.sum);

  // round half up back to q16.16, then clamp
  assign rnd_full = {1'b0, prod} + (rpwu_pkg::PROD_W+1)'(32768);
  assign rnd      = rnd_full[rpwu_pkg::PROD_W:rpwu_pkg::FRAC_W];
  assign grown    = (rnd > RND_W'(cfg.max_step)) ? cfg.max_step : rnd[SW-1:0];
  assign shrunk   = (rnd < RND_W'(cfg.min_step)) ? cfg.min_step : rnd[SW-1:0];
  assign mv_step  = (dir == rpwu_pkg::DIR_GROW) ? grown : ent.step;

  // weight moves against the sign of the sum
  always_comb begin
    w_ext = {ent.weight[VW-1], ent.weight};
    if (ent.sum[VW-1]) begin
      w_mv = w_ext + $signed({2'b00, mv_step});
    end else if (ent.sum != '0) begin
      w_mv = w_ext - $signed({2'b00, mv_step});
    end else begin
      w_mv = w_ext;
    end
  end

  assign w_sat  = w_mv[VW] != w_mv[VW-1];
  assign w_clip = w_sat ? {w_mv[VW], {(VW-1){~w_mv[VW]}}} : w_mv[VW-1:0];

  assign acc      = {ent.sum[VW-1], ent.sum} + {operand[VW-1], operand};
  assign acc_sat  = acc[VW] != acc[VW-1];
  assign acc_clip = acc_sat ? {acc[VW], {(VW-1){~acc[VW]}}} : acc[VW-1:0];

  always_comb begin
    nxt  = ent;
    kind = rpwu_pkg::KIND_NONE;
    sat  = 1'b0;
    case (op)
      rpwu_pkg::OP_LOAD: begin
        nxt.weight = operand;
        nxt.step   = cfg.initial_step;
        nxt.prev   = '0;
        nxt.sum    = '0;
      end
      rpwu_pkg::OP_ACC: begin
        nxt.sum = acc_clip;
        sat     = acc_sat;
      end
      rpwu_pkg::OP_UPD: begin
        nxt.sum = '0;
        if (dir == rpwu_pkg::DIR_SHRINK) begin
          nxt.step = shrunk;
          nxt.prev = '0;
          kind     = rpwu_pkg::KIND_SHRANK;
        end else begin
          nxt.step   = mv_step;
          nxt.weight = w_clip;
          nxt.prev   = ent.sum;
          sat        = w_sat;
          kind       = (dir == rpwu_pkg::DIR_GROW) ? rpwu_pkg::KIND_GREW
                                                   : rpwu_pkg::KIND_SAME;
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// ----- src/rprop_weight_update_engine.sv -----
`default_nettype none
// rprop_weight_update_engine: top level, sequencer around the entry memory
//
// iRprop- weight update engine. Each of ENTRY_COUNT entries (weight, step,
// previous gradient, gradient sum) lives in one wide single port memory with
// a registered read. An item is a load, accumulate, update or read of one
// entry and gives exactly one result. Every item goes through the sequencer
// states in turn: the transfer cycle issues the memory read, then the entry
// and the step times factor product are registered, and then the new entry
// is computed, written back and loaded into the output register. No new item
// is taken until the last one has been written back. A waiting result only
// holds the write back cycle, the next item is taken while it waits. Items
// run strictly one after another, so no two memory accesses to the same
// entry ever overlap. Memory contents are undefined until an entry is loaded;
// there is no clearing pass after reset.
// Indexes at or beyond ENTRY_COUNT are not stored and return weight 0,
// step 0, step kind 3. Registers sit on an apb port at byte address 4*i:
// grow_factor, shrink_factor, max_step, min_step, initial_step; write them
// only while the block is idle.
module rprop_weight_update_engine (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // input channel
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic [1:0]                          in_op,
  input  wire logic [rpwu_pkg::IDX_W-1:0]          in_entry_index,
  input  wire logic signed [rpwu_pkg::VAL_W-1:0]   in_operand_value,
  // result channel
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic [rpwu_pkg::IDX_W-1:0]               out_result_index,
  output logic signed [rpwu_pkg::VAL_W-1:0]        out_result_weight,
  output logic [rpwu_pkg::STEP_W-1:0]              out_result_step,
  output logic [1:0]                               out_step_kind,
  output logic                                     out_saturated,
  // configuration port
  input  wire logic                                cfg_psel,
  input  wire logic                                cfg_penable,
  input  wire logic                                cfg_pwrite,
  input  wire logic [rpwu_pkg::PADDR_W-1:0]        cfg_paddr,
  input  wire logic [31:0]                         cfg_pwdata,
  output logic      [31:0]                         cfg_prdata,
  output logic                                     cfg_pready
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RD   = 2'd1;
  localparam logic [1:0] ST_WB   = 2'd2;

  localparam int AW = rpwu_pkg::ADDR_W;

  logic [1:0]                          state_r, state_nxt;
  // item registers
  logic [1:0]                          op_r;
  logic [rpwu_pkg::IDX_W-1:0]          idx_r;
  logic signed [rpwu_pkg::VAL_W-1:0]   operand_r;
  logic                                in_range_r;
  // read stage registers
  rpwu_pkg::entry_t                    ent_r;
  logic [rpwu_pkg::PROD_W-1:0]         prod_r;
  // output register
  logic                                out_valid_r;
  logic [rpwu_pkg::IDX_W-1:0]          out_index_r;
  logic signed [rpwu_pkg::VAL_W-1:0]   out_weight_r;
  logic [rpwu_pkg::STEP_W-1:0]         out_step_r;
  logic [1:0]                          out_kind_r;
  logic                                out_sat_r;

  rpwu_pkg::cfg_t                      cfg;
  rpwu_pkg::entry_t                    ram_rd;
  rpwu_pkg::entry_t                    new_ent;
  logic [1:0]                          new_kind;
  logic                                new_sat;
  logic [rpwu_pkg::ENTRY_W-1:0]        ram_rdata;
  logic [AW-1:0]                       ram_addr;
  logic                                ram_we;
  logic                                in_xfer;
  logic                                out_free;
  logic                                wb_go;
  logic [rpwu_pkg::GROW_W-1:0]         factor;

  assign cfg_pready = 1'b1;

  rpwu_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .cfg     (cfg)
  );

  // handshakes: take an item only when no other item is in flight
  assign in_ready = (state_r == ST_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign wb_go    = (state_r == ST_WB) && out_free;

  // the memory address follows the input while idle, the held item otherwise
  assign ram_addr = (state_r == ST_IDLE) ? AW'(in_entry_index) : AW'(idx_r);
  assign ram_we   = wb_go && in_range_r && (op_r != rpwu_pkg::OP_READ);

  rpwu_ram #(
    .WIDTH (rpwu_pkg::ENTRY_W),
    .DEPTH (rpwu_pkg::ENTRY_COUNT)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (new_ent),
    .rdata (ram_rdata)
  );

  assign ram_rd = ram_rdata;

  // one multiplier: grow factor unless the gradients disagree
  assign factor = (rpwu_pkg::grad_dir(ram_rd.prev, ram_rd.sum) == rpwu_pkg::DIR_SHRINK)
                ? rpwu_pkg::GROW_W'(cfg.shrink_factor) : cfg.grow_factor;

  rpwu_calc u_calc (
    .op      (op_r),
    .operand (operand_r),
    .ent     (ent_r),
    .prod    (prod_r),
    .cfg     (cfg),
    .nxt     (new_ent),
    .kind    (new_kind),
    .sat     (new_sat)
  );

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_xfer) state_nxt = ST_RD;
      ST_RD:   state_nxt = ST_WB;
      ST_WB:   if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (wb_go) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // item capture on transfer
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      op_r       <= in_op;
      idx_r      <= in_entry_index;
      operand_r  <= in_operand_value;
      in_range_r <= int'(in_entry_index) < rpwu_pkg::ENTRY_COUNT;
    end
  end

  // entry and scaled step registered after the memory read
  always_ff @(posedge clk) begin
    if (state_r == ST_RD) begin
      ent_r  <= ram_rd;
      prod_r <= ram_rd.step * factor;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (wb_go) begin
      out_index_r <= idx_r;
      if (in_range_r) begin
        out_weight_r <= new_ent.weight;
        out_step_r   <= new_ent.step;
        out_kind_r   <= new_kind;
        out_sat_r    <= new_sat;
      end else begin
        out_weight_r <= '0;
        out_step_r   <= '0;
        out_kind_r   <= rpwu_pkg::KIND_NONE;
        out_sat_r    <= 1'b0;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_result_index  = out_index_r;
  assign out_result_weight = out_weight_r;
  assign out_result_step   = out_step_r;
  assign out_step_kind     = out_kind_r;
  assign out_saturated     = out_sat_r;

endmodule
`default_nettype wire

// ----- bench/rprop_check_pkg.sv -----
`timescale 1ns / 1ps
// rprop_check_pkg: entry-state tracker and result checker for the rprop engine bench
package rprop_check_pkg;
  import rpwu_pkg::*;

  typedef struct packed {
    logic [IDX_W-1:0]        idx;
    logic signed [VAL_W-1:0] weight;
    logic [STEP_W-1:0]       step;
    logic [1:0]              kind;
    logic                    sat;
  } entry_result_t;

  class rprop_tracker;
    // shadow copy of the entry memory, only ever read after a load
    logic signed [VAL_W-1:0] weight_mem [ENTRY_COUNT];
    logic [STEP_W-1:0]       step_mem   [ENTRY_COUNT];
    logic signed [VAL_W-1:0] prev_mem   [ENTRY_COUNT];
    logic signed [VAL_W-1:0] sum_mem    [ENTRY_COUNT];

    logic [GROW_W-1:0]   grow_factor   = 18'd78643;
    logic [SHRINK_W-1:0] shrink_factor = 16'd32768;
    logic [STEP_W-1:0]   max_step      = 31'd3276800;
    logic [STEP_W-1:0]   min_step      = 31'd1;
    logic [STEP_W-1:0]   initial_step  = 31'd6554;

    entry_result_t expected_results[$];
    int errors;
    int checked;
    int sat_count;
    int kind_count[4];

    static function int sign_of(logic signed [VAL_W-1:0] v);
      if (v > 0) return 1;
      if (v < 0) return -1;
      return 0;
    endfunction

    // step times Q16.16 factor, rounded half up back to Q16.16
    static function logic [63:0] scale_step(logic [STEP_W-1:0] step,
                                            logic [GROW_W-1:0] factor);
      logic [63:0] a;
      logic [63:0] b;
      a = step;
      b = factor;
      return (a * b + 64'h8000) >> FRAC_W;
    endfunction

    static function logic signed [VAL_W-1:0] clip_word(longint v, output bit hit);
      hit = 1'b0;
      if (v > 64'sd2147483647) begin
        hit = 1'b1;
        return 32'sh7FFF_FFFF;
      end
      if (v < -64'sd2147483648) begin
        hit = 1'b1;
        return 32'sh8000_0000;
      end
      return v[VAL_W-1:0];
    endfunction

    function void set_reg(logic [2:0] which, logic [31:0] v);
      case (which)
        REG_GROW:     grow_factor   = v[GROW_W-1:0];
        REG_SHRINK:   shrink_factor = v[SHRINK_W-1:0];
        REG_MAXSTEP:  max_step      = v[STEP_W-1:0];
        REG_MINSTEP:  min_step      = v[STEP_W-1:0];
        REG_INITSTEP: initial_step  = v[STEP_W-1:0];
        default: ;
      endcase
    endfunction

    // apply one accepted item to the shadow entry and queue the result it gives
    function void take_item(logic [1:0] op, logic [IDX_W-1:0] idx,
                            logic signed [VAL_W-1:0] val);
      entry_result_t r;
      longint acc;
      longint w_next;
      longint mag;
      logic [63:0] scaled;
      logic [STEP_W-1:0] st;
      logic signed [VAL_W-1:0] sum;
      int dir;
      bit hit;
      r = '0;
      r.idx = idx;
      r.kind = KIND_NONE;
      hit = 1'b0;
      case (op)
        OP_LOAD: begin
          weight_mem[idx] = val;
          step_mem[idx] = initial_step;
          prev_mem[idx] = '0;
          sum_mem[idx] = '0;
        end
        OP_ACC: begin
          acc = sum_mem[idx];
          acc += val;
          sum_mem[idx] = clip_word(acc, hit);
        end
        OP_UPD: begin
          sum = sum_mem[idx];
          dir = sign_of(prev_mem[idx]) * sign_of(sum);
          st = step_mem[idx];
          if (dir < 0) begin
            // sign flip: back off, forget the gradient, hold the weight
            scaled = scale_step(st, shrink_factor);
            if (scaled < min_step) scaled = min_step;
            st = scaled[STEP_W-1:0];
            prev_mem[idx] = '0;
            r.kind = KIND_SHRANK;
          end else begin
            if (dir > 0) begin
              scaled = scale_step(st, grow_factor);
              if (scaled > max_step) scaled = max_step;
              st = scaled[STEP_W-1:0];
              r.kind = KIND_GREW;
            end else begin
              r.kind = KIND_SAME;
            end
            mag = st;
            w_next = weight_mem[idx];
            w_next -= sign_of(sum) * mag;
            weight_mem[idx] = clip_word(w_next, hit);
            prev_mem[idx] = sum;
          end
          step_mem[idx] = st;
          sum_mem[idx] = '0;
        end
        OP_READ: ;
        default: ;
      endcase
      r.weight = weight_mem[idx];
      r.step = step_mem[idx];
      r.sat = hit;
      expected_results.push_back(r);
    endfunction

    function void match_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(entry_result_t got);
      entry_result_t want;
      if (expected_results.size() == 0) begin
        $error("result for entry %0d with nothing outstanding", got.idx);
        errors++;
        return;
      end
      want = expected_results.pop_front();
      match_field("result_index", want.idx, got.idx);
      match_field("result_weight", want.weight, got.weight);
      match_field("result_step", want.step, got.step);
      match_field("step_kind", want.kind, got.kind);
      match_field("saturated", want.sat, got.sat);
      checked++;
      kind_count[got.kind]++;
      if (got.sat) sat_count++;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction
  endclass

endpackage

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
// tb_top: self-checking bench for the rprop weight update engine
module tb_top;
  import rpwu_pkg::*;
  import rprop_check_pkg::*;

  localparam logic signed [VAL_W-1:0] W_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [VAL_W-1:0] W_MIN = 32'sh8000_0000;

  logic clk;
  logic rst_n = 1'b0;

  // input channel
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic [1:0]              in_op = OP_LOAD;
  logic [IDX_W-1:0]        in_entry_index = '0;
  logic signed [VAL_W-1:0] in_operand_value = '0;

  // result channel
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic [IDX_W-1:0]        out_result_index;
  logic signed [VAL_W-1:0] out_result_weight;
  logic [STEP_W-1:0]       out_result_step;
  logic [1:0]              out_step_kind;
  logic                    out_saturated;

  // register port
  logic               cfg_psel = 1'b0;
  logic               cfg_penable = 1'b0;
  logic               cfg_pwrite = 1'b0;
  logic [PADDR_W-1:0] cfg_paddr = '0;
  logic [31:0]        cfg_pwdata = '0;
  logic [31:0]        cfg_prdata;
  logic               cfg_pready;

  rprop_tracker tracker = new();

  // random idle cycles on both sides while set, clear for a clean stretch
  bit gaps_on = 1'b1;
  // one-shot request for a long receiver hold-off
  bit hold_req = 1'b0;
  int hold_left = 0;
  int op_count[4];
  // per-entry gradient sign, flipped now and then so grow and shrink both show up
  bit grad_neg [ENTRY_COUNT];

  rprop_weight_update_engine u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_op             (in_op),
    .in_entry_index    (in_entry_index),
    .in_operand_value  (in_operand_value),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_result_index  (out_result_index),
    .out_result_weight (out_result_weight),
    .out_result_step   (out_result_step),
    .out_step_kind     (out_step_kind),
    .out_saturated     (out_saturated),
    .cfg_psel          (cfg_psel),
    .cfg_penable       (cfg_penable),
    .cfg_pwrite        (cfg_pwrite),
    .cfg_paddr         (cfg_paddr),
    .cfg_pwdata        (cfg_pwdata),
    .cfg_prdata        (cfg_prdata),
    .cfg_pready        (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // hard stop in case a handshake never completes
  initial begin
    #5000000;
    $display("CHECKS FAILED");
    $finish;
  end

  // offer one item, hold it until the transfer, then hand it to the tracker
  task automatic send_item(input logic [1:0] op, input logic [IDX_W-1:0] idx,
                           input logic signed [VAL_W-1:0] val);
    if (gaps_on) begin
      while ($urandom_range(99) < 20) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_op <= op;
    in_entry_index <= idx;
    in_operand_value <= val;
    do @(posedge clk); while (!in_ready);
    tracker.take_item(op, idx, val);
    op_count[op]++;
  endtask

  // drop valid and wait until every outstanding result is back
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  // setup cycle then access cycle; bits above the register width carry junk half the time
  task automatic write_reg(input logic [2:0] which, input logic [31:0] value);
    int w;
    logic [31:0] data;
    case (which)
      REG_GROW:   w = GROW_W;
      REG_SHRINK: w = SHRINK_W;
      default:    w = STEP_W;
    endcase
    data = value;
    if ($urandom_range(1)) data = data | 32'($urandom() << w);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {which, 2'b00};
    cfg_pwdata <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    tracker.set_reg(which, data);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // registers only change with the engine empty: drain first, then idle before writing
  task automatic reconfigure(input logic [31:0] grow, input logic [31:0] shrink,
                             input logic [31:0] max_s, input logic [31:0] min_s,
                             input logic [31:0] init_s);
    wait_drained();
    repeat (4) @(posedge clk);
    write_reg(REG_GROW, grow);
    write_reg(REG_SHRINK, shrink);
    write_reg(REG_MAXSTEP, max_s);
    write_reg(REG_MINSTEP, min_s);
    write_reg(REG_INITSTEP, init_s);
  endtask

  // weights near either rail, small or random, so large steps clip
  function automatic logic signed [VAL_W-1:0] rand_weight();
    case ($urandom_range(3))
      0: return W_MAX - $urandom_range(0, 1 << 20);
      1: return W_MIN + $urandom_range(0, 1 << 20);
      2: return $urandom_range(0, 1 << 22) - (1 << 21);
      default: return $urandom();
    endcase
  endfunction

  // mostly small gradients with a sticky sign, some full range, rails and zero
  function automatic logic signed [VAL_W-1:0] rand_grad(input int unsigned idx);
    logic [31:0] mag;
    case ($urandom_range(9))
      0: return $urandom();
      1: return $urandom_range(1) ? W_MAX : W_MIN;
      2: return '0;
      default: begin
        if ($urandom_range(99) < 20) grad_neg[idx] = ~grad_neg[idx];
        mag = $urandom_range(1, 1 << 18);
        return grad_neg[idx] ? -mag : mag;
      end
    endcase
  endfunction

  // training-like traffic: load a working set, then accumulate/update rounds with reads
  task automatic train_phase(input int n_items, input bit pause_mid, input bit hold_mid);
    int unsigned pool[$];
    int unsigned idx;
    int pick;
    pool = {};
    repeat (16) begin
      idx = $urandom_range(ENTRY_COUNT - 1);
      pool.push_back(idx);
      send_item(OP_LOAD, IDX_W'(idx), rand_weight());
    end
    for (int n = 0; n < n_items; n++) begin
      // sender stops until the engine has handed back everything
      if (pause_mid && n == n_items / 3) wait_drained();
      // receiver goes quiet while we keep offering, so the engine backs up
      if (hold_mid && n == n_items / 2) hold_req = 1'b1;
      idx = pool[$urandom_range(pool.size() - 1)];
      pick = $urandom_range(99);
      if (pick < 6) begin
        send_item(OP_LOAD, IDX_W'(idx), rand_weight());
      end else if (pick < 9) begin
        idx = $urandom_range(ENTRY_COUNT - 1);
        pool.push_back(idx);
        send_item(OP_LOAD, IDX_W'(idx), rand_weight());
      end else if (pick < 55) begin
        send_item(OP_ACC, IDX_W'(idx), rand_grad(idx));
      end else if (pick < 85) begin
        send_item(OP_UPD, IDX_W'(idx), $urandom());
      end else begin
        send_item(OP_READ, IDX_W'(idx), $urandom());
      end
    end
  endtask

  // result side: check every transfer, stall at random or on request
  initial begin
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        tracker.check_result({out_result_index, out_result_weight, out_result_step,
                              out_step_kind, out_saturated});
      end
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = 120;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (gaps_on) begin
        out_ready <= ($urandom_range(99) >= 20);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part, register reset values
    send_item(OP_LOAD, 10'd0, W_MAX);
    send_item(OP_LOAD, 10'd1023, W_MIN);
    send_item(OP_LOAD, 10'd5, '0);
    send_item(OP_LOAD, 10'd2, W_MAX);
    send_item(OP_LOAD, 10'd3, W_MIN);
    send_item(OP_READ, 10'd0, $urandom());
    send_item(OP_READ, 10'd1023, $urandom());
    // gradient sum pinned at both rails
    send_item(OP_ACC, 10'd0, W_MAX);
    send_item(OP_ACC, 10'd0, 32'sd1);
    send_item(OP_ACC, 10'd1023, W_MIN);
    send_item(OP_ACC, 10'd1023, -32'sd1);
    // weight pushed past either rail by the move
    send_item(OP_ACC, 10'd2, -32'sd5);
    send_item(OP_ACC, 10'd3, 32'sd5);
    send_item(OP_UPD, 10'd2, '0);
    send_item(OP_UPD, 10'd3, '0);
    // no gradient history yet: move without step change
    send_item(OP_UPD, 10'd0, '0);
    send_item(OP_UPD, 10'd1023, '0);
    // empty sum leaves the weight alone
    send_item(OP_UPD, 10'd5, '0);
    // same sign again grows, then a flip shrinks
    send_item(OP_ACC, 10'd0, 32'sd3);
    send_item(OP_UPD, 10'd0, '0);
    send_item(OP_ACC, 10'd0, -32'sd3);
    send_item(OP_UPD, 10'd0, 32'sh1234_5678);
    send_item(OP_READ, 10'd5, W_MIN);

    // moderate settings, with a full drain partway through
    reconfigure(32'd131072, 32'd32768, 32'd1048576, 32'd16, 32'd65536);
    train_phase(95, 1'b1, 1'b0);
    // top of every range but min_step, which is 0: steps hit the clamp and weights clip
    reconfigure(32'd262143, 32'd65535, 32'h7FFF_FFFF, 32'd0, 32'h7FFF_FFFF);
    train_phase(95, 1'b0, 1'b1);
    // bottom of every range but grow_factor, which is 1.0, no idling on either side
    gaps_on = 1'b0;
    reconfigure(32'd65536, 32'd0, 32'd0, 32'd0, 32'd0);
    train_phase(95, 1'b0, 1'b0);
    gaps_on = 1'b1;
    // floor above ceiling
    reconfigure(32'd98304, 32'd16384, 32'd4096, 32'h7FFF_FFFF, 32'd1000);
    train_phase(95, 1'b1, 1'b0);
    // random settings
    reconfigure($urandom_range(65536, 262143), $urandom_range(0, 65535),
                $urandom_range(0, 1 << 24), $urandom_range(0, 4096),
                $urandom_range(0, 1 << 20));
    train_phase(95, 1'b0, 1'b1);

    wait_drained();
    repeat (10) @(posedge clk);

    $display("run covered %0d loads, %0d accumulates, %0d updates, %0d reads over six settings",
             op_count[OP_LOAD], op_count[OP_ACC], op_count[OP_UPD], op_count[OP_READ]);
    $display("%0d results checked: grew %0d, shrank %0d, unchanged %0d, clipped %0d",
             tracker.checked, tracker.kind_count[KIND_GREW], tracker.kind_count[KIND_SHRANK],
             tracker.kind_count[KIND_SAME], tracker.sat_count);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
